/* rtl/core/udiv_pkg.sv */
// Shared widths, controller state encoding and command/status types for the divider.
package udiv_pkg;

    localparam int unsigned DIVIDEND_W = 64;
    localparam int unsigned DIVISOR_W  = 32;
    localparam int unsigned STEP_CNT_W = $clog2(DIVIDEND_W);
    localparam int unsigned S_TDATA_W  = ((DIVIDEND_W + DIVISOR_W + 7) / 8) * 8;
    localparam int unsigned M_TDATA_W  = ((DIVIDEND_W + DIVISOR_W + 7) / 8) * 8;

    localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(DIVIDEND_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_BUSY   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic divisor_zero;
        logic last_step;
    } status_t;

endpackage

/* rtl/core/unsigned_divide_64_by_32_top.sv */
// Top level of the unsigned 64-by-32 restoring divider.
//
//  Channel  Direction  Payload
//  s_       in         tdata: dividend[63:0], divisor[95:64]
//  m_       out        tdata: quotient[63:0], remainder[95:64]; tuser: divide_by_zero
//
// For a nonzero divisor the operands load on the input transfer itself, then the single
// shift-and-subtract stage iterates once per dividend bit, and the result register loads
// as soon as it is free (empty or being taken). A zero divisor skips the iterations.
// One item is in the iteration stage at a time; a finished result may wait in the
// output register while the next item is accepted and divided.
// aresetn is synchronous, active low, and clears the controller and the valid flag.
module unsigned_divide_64_by_32_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [udiv_pkg::S_TDATA_W-1:0]  s_tdata,   // dividend, divisor
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [udiv_pkg::M_TDATA_W-1:0]  m_tdata,   // quotient, remainder
    output logic                            m_tuser    // divide_by_zero
);

    udiv_pkg::cmd_t    cmd;
    udiv_pkg::status_t status;

    udiv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    udiv_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .cmd     (cmd),
        .status  (status)
    );

endmodule

/* rtl/core/udiv_ctrl.sv */
// Sequencing state machine and result valid flag for the divider.
module udiv_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  udiv_pkg::status_t status,
    output udiv_pkg::cmd_t   cmd
);

    udiv_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;
    logic             in_xfer;
    logic             out_free;

    assign s_tready = (state_reg == udiv_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next   = state_reg;
        cmd.load     = 1'b0;
        cmd.step     = 1'b0;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            udiv_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    cmd.load   = 1'b1;
                    state_next = status.divisor_zero ? udiv_pkg::ST_FINISH
                                                     : udiv_pkg::ST_BUSY;
                end
            end
            udiv_pkg::ST_BUSY: begin
                cmd.step = 1'b1;
                if (status.last_step) begin
                    state_next = udiv_pkg::ST_FINISH;
                end
            end
            udiv_pkg::ST_FINISH: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = udiv_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = udiv_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= udiv_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/core/udiv_datapath.sv */
// Restoring shift-and-subtract datapath with step counter and result register.
module udiv_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [udiv_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic [udiv_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tuser,
    input  udiv_pkg::cmd_t                      cmd,
    output udiv_pkg::status_t                   status
);

    localparam int unsigned QW = udiv_pkg::DIVIDEND_W;
    localparam int unsigned DW = udiv_pkg::DIVISOR_W;
    localparam int unsigned CW = udiv_pkg::STEP_CNT_W;

    logic [QW-1:0] shift_reg, shift_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] den_reg, den_next;
    logic          dbz_reg, dbz_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic [QW-1:0] quo_out_reg, quo_out_next;
    logic [DW-1:0] rem_out_reg, rem_out_next;
    logic          dbz_out_reg, dbz_out_next;

    logic [QW-1:0] in_dividend;
    logic [DW-1:0] in_divisor;
    logic [DW:0]   trial;
    logic [DW+1:0] diff;
    logic          fits;

    assign in_dividend = s_tdata[QW-1:0];
    assign in_divisor  = s_tdata[QW+DW-1:QW];

    assign trial = {rem_reg, shift_reg[QW-1]};
    assign diff  = {1'b0, trial} - {2'b00, den_reg};
    assign fits  = !diff[DW+1];

    assign status.divisor_zero = (in_divisor == '0);
    assign status.last_step    = (cnt_reg == udiv_pkg::LAST_STEP);

    always_comb begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        dbz_next   = dbz_reg;
        cnt_next   = cnt_reg;
        if (cmd.load) begin
            shift_next = in_dividend;
            rem_next   = '0;
            den_next   = in_divisor;
            dbz_next   = status.divisor_zero;
            cnt_next   = '0;
        end else if (cmd.step) begin
            shift_next = {shift_reg[QW-2:0], fits};
            rem_next   = fits ? diff[DW-1:0] : trial[DW-1:0];
            cnt_next   = cnt_reg + CW'(1);
        end
    end

    always_comb begin
        quo_out_next = quo_out_reg;
        rem_out_next = rem_out_reg;
        dbz_out_next = dbz_out_reg;
        if (cmd.out_load) begin
            quo_out_next = dbz_reg ? '1 : shift_reg;
            rem_out_next = dbz_reg ? shift_reg[DW-1:0] : rem_reg;
            dbz_out_next = dbz_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg   <= shift_next;
        rem_reg     <= rem_next;
        den_reg     <= den_next;
        dbz_reg     <= dbz_next;
        quo_out_reg <= quo_out_next;
        rem_out_reg <= rem_out_next;
        dbz_out_reg <= dbz_out_next;
    end

    assign m_tdata = udiv_pkg::M_TDATA_W'({rem_out_reg, quo_out_reg});
    assign m_tuser = dbz_out_reg;

endmodule

/* rtl/core/udiv_checker.sv */
// Port-level assertions for the divider, bound to the top level.
module udiv_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [udiv_pkg::S_TDATA_W-1:0]  s_tdata,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [udiv_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                            m_tuser
);

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_busy_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready while divide in progress");

    a_result_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a divide in progress");

    a_zero_quotient_ones: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata[udiv_pkg::DIVIDEND_W-1:0] == '1))
        else $error("divide-by-zero result without all-ones quotient");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind unsigned_divide_64_by_32_top udiv_checker u_udiv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* bench/tb_unsigned_divide_64_by_32_top.sv */
// Self-checking bench for the 64-by-32 unsigned divider: bursty stream stimulus, stalled results.
`timescale 1ns / 1ps

module tb_unsigned_divide_64_by_32_top;

    localparam int unsigned RANDOM_ITEMS = 450;
    localparam int unsigned DRAIN_CYCLES = 80;
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned PRINT_CAP    = 100;

    typedef struct {
        logic [udiv_pkg::DIVIDEND_W-1:0] quotient;
        logic [udiv_pkg::DIVISOR_W-1:0]  remainder;
        logic                            div_zero;
    } div_result_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [udiv_pkg::S_TDATA_W-1:0]  s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [udiv_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                            m_tuser;

    logic [udiv_pkg::S_TDATA_W-1:0]  operand_q[$];
    div_result_t                     quot_rem_q[$];

    bit                    s_fire = 1'b0;
    int unsigned           item_total = 0;
    int unsigned           zero_div_items = 0;
    int unsigned           n_accepted = 0;
    int unsigned           n_checked = 0;
    int unsigned           n_zero_seen = 0;
    int unsigned           n_errors = 0;
    int unsigned           cycle_cnt = 0;
    int unsigned           burst_left = 0;
    int unsigned           gap_left = 0;
    int unsigned           rx_left = 0;

    unsigned_divide_64_by_32_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic div_result_t udiv_restoring(
            input logic [udiv_pkg::DIVIDEND_W-1:0] num,
            input logic [udiv_pkg::DIVISOR_W-1:0]  den);
        div_result_t                    r;
        logic [udiv_pkg::DIVISOR_W:0]   part;
        int                             k;
        r.quotient  = '0;
        r.remainder = '0;
        r.div_zero  = 1'b0;
        part        = '0;
        if (den == '0) begin
            r.quotient  = '1;
            r.remainder = num[udiv_pkg::DIVISOR_W-1:0];
            r.div_zero  = 1'b1;
        end else begin
            for (k = udiv_pkg::DIVIDEND_W - 1; k >= 0; k--) begin
                part = {part[udiv_pkg::DIVISOR_W-1:0], num[k]};
                if (part >= {1'b0, den}) begin
                    part = part - {1'b0, den};
                    r.quotient[k] = 1'b1;
                end
            end
            r.remainder = part[udiv_pkg::DIVISOR_W-1:0];
        end
        return r;
    endfunction

    task automatic push_operands(input logic [udiv_pkg::DIVIDEND_W-1:0] dvd,
                                 input logic [udiv_pkg::DIVISOR_W-1:0]  dvs);
        operand_q.push_back({dvs, dvd});
        item_total++;
        if (dvs == '0) begin
            zero_div_items++;
        end
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        n_errors++;
        if (n_errors <= PRINT_CAP) begin
            $display("%0t: result %0d, %s wrong: got %h, expected %h",
                     $realtime, n_checked, field, got, want);
        end
    endtask

    // sender: bursts of transfers separated by random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_fire) begin
            if (gap_left != 0 || operand_q.size() == 0) begin
                if (gap_left != 0) begin
                    gap_left--;
                end
                s_tvalid <= 1'b0;
            end else begin
                s_tdata  <= operand_q.pop_front();
                s_tvalid <= 1'b1;
                if (burst_left != 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 12);
                    case ($urandom_range(0, 3))
                        0: gap_left = 0;
                        1: gap_left = $urandom_range(1, 4);
                        2: gap_left = $urandom_range(5, 40);
                        default: gap_left = $urandom_range(41, 90);
                    endcase
                end
            end
        end
    end

    // receiver: alternate ready stretches and stalls, now and then a long clear run
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_left != 0) begin
            rx_left--;
        end else if (m_tready) begin
            m_tready <= 1'b0;
            rx_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(0, 3);
        end else begin
            m_tready <= 1'b1;
            rx_left = ($urandom_range(0, 4) == 0) ? 400 : $urandom_range(0, 6);
        end
    end

    always @(posedge aclk) begin
        div_result_t want;
        s_fire = aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (quot_rem_q.size() == 0) begin
                    report_mismatch("transfer with no result outstanding",
                                    m_tdata[63:0], '0);
                end else begin
                    want = quot_rem_q.pop_front();
                    if (m_tdata[udiv_pkg::DIVIDEND_W-1:0] !== want.quotient) begin
                        report_mismatch("quotient", m_tdata[udiv_pkg::DIVIDEND_W-1:0],
                                        want.quotient);
                    end
                    if (m_tdata[udiv_pkg::DIVIDEND_W +: udiv_pkg::DIVISOR_W]
                            !== want.remainder) begin
                        report_mismatch("remainder",
                                        m_tdata[udiv_pkg::DIVIDEND_W +: udiv_pkg::DIVISOR_W],
                                        want.remainder);
                    end
                    if (m_tuser !== want.div_zero) begin
                        report_mismatch("divide_by_zero", m_tuser, want.div_zero);
                    end
                    if (want.div_zero) begin
                        n_zero_seen++;
                    end
                    n_checked++;
                end
            end
            if (s_fire) begin
                quot_rem_q.push_back(udiv_restoring(
                    s_tdata[udiv_pkg::DIVIDEND_W-1:0],
                    s_tdata[udiv_pkg::DIVIDEND_W +: udiv_pkg::DIVISOR_W]));
                n_accepted++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timed out after %0d cycles: %0d of %0d items taken, %0d results due",
                     cycle_cnt, n_accepted, item_total, quot_rem_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        logic [udiv_pkg::DIVIDEND_W-1:0] dvd;
        logic [udiv_pkg::DIVISOR_W-1:0]  dvs;
        int                              i;

        push_operands(64'h0, 32'h1);
        push_operands('1, 32'h1);
        push_operands('1, '1);
        push_operands('1, 32'h0);
        push_operands(64'h0, 32'h0);
        push_operands(64'h0123_4567_89AB_CDEF, 32'h0);
        push_operands(64'h1, 32'h0);
        push_operands(64'h1, '1);
        push_operands(64'hFFFF_FFFE_0000_0001, '1);
        push_operands(64'h8000_0000_0000_0000, 32'h8000_0000);
        push_operands(64'h0000_0000_FFFF_FFFF, '1);
        push_operands(64'h0000_0000_FFFF_FFFE, '1);
        push_operands(64'h0000_0001_0000_0000, 32'h2);
        push_operands('1, 32'h2);
        push_operands(64'hFFFF_FFFF_0000_0000, '1);
        push_operands(64'hDEAD_BEEF_CAFE_F00D, 32'h3);
        push_operands(64'h5555_5555_5555_5555, 32'hAAAA_AAAA);
        push_operands(64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555);
        push_operands(64'h7, 32'h8);
        push_operands(64'h8000_0000_0000_0001, 32'h8000_0001);

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            case ($urandom_range(0, 9))
                0: begin
                    dvd = {$urandom, $urandom};
                    dvs = '0;
                end
                1, 2: begin
                    dvd = {$urandom, $urandom};
                    dvs = $urandom_range(1, 255);
                end
                3: begin
                    dvd = {32'h0, $urandom};
                    dvs = $urandom;
                end
                4: begin
                    dvd = {$urandom, $urandom} >> $urandom_range(0, 63);
                    dvs = $urandom >> $urandom_range(0, 31);
                end
                5: begin
                    dvs = $urandom | 32'h1;
                    dvd = 64'($urandom) * 64'(dvs) + 64'($urandom_range(0, dvs - 1));
                end
                default: begin
                    dvd = {$urandom, $urandom};
                    dvs = $urandom;
                end
            endcase
            push_operands(dvd, dvs);
        end

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        while (!(n_accepted == item_total && quot_rem_q.size() == 0)) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("divided %0d operand pairs (%0d with a zero divisor) under bursty input",
                 item_total, zero_div_items);
        $display("checked %0d results, %0d of them flagged divide by zero, %0d errors",
                 n_checked, n_zero_seen, n_errors);
        if (n_errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/udiv_pkg.sv
rtl/core/udiv_ctrl.sv
rtl/core/udiv_datapath.sv
rtl/core/unsigned_divide_64_by_32_top.sv
rtl/core/udiv_checker.sv
bench/tb_unsigned_divide_64_by_32_top.sv
